// ----- design/irm_pkg.sv -----
package irm_pkg;

    // reply kinds as shown on the result tuser
    typedef enum logic [1:0] {
        KIND_OTHER         = 2'd0,
        KIND_ECHO          = 2'd1,
        KIND_TIME_EXCEEDED = 2'd2,
        KIND_TRUNCATED     = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] REG_PROBE_DEST_ADDR = 2'd0;
    localparam logic [1:0] REG_PROBE_SEQUENCE  = 2'd1;
    localparam logic [1:0] REG_PROBE_ID        = 2'd2;

    // icmp message types and header sizes
    localparam logic [7:0] MSG_ECHO_REPLY     = 8'd0;
    localparam logic [7:0] MSG_TIME_EXCEEDED  = 8'd11;
    localparam logic [7:0] ICMP_HDR_LEN       = 8'd8;
    localparam logic [7:0] ECHO_SEQ_OFFSET    = 8'd6;
    localparam logic [7:0] QUOTED_ID_OFFSET   = 8'd4;
    localparam logic [7:0] OFFSET_MAX         = 8'hFF;

    localparam int QUEUE_DEPTH = 2;

    // one classified packet, handed from the parser to the verdict stage
    typedef struct packed {
        kind_t       kind;
        logic [15:0] field;
        logic [31:0] sender;
    } verdict_t;

endpackage

// ----- design/irm_front.sv -----
module irm_front
    import irm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] sender_addr,
    output logic        push,
    output verdict_t    push_data
);

    logic [7:0]  offset_reg,    offset_next;
    logic [5:0]  outer_len_reg, outer_len_next;
    logic [7:0]  msg_type_reg,  msg_type_next;
    logic [5:0]  inner_len_reg, inner_len_next;
    logic [15:0] field_reg,     field_next;
    logic        complete_reg,  complete_next;
    logic [31:0] sender_reg,    sender_next;

    logic [7:0]  outer_ext;
    logic [7:0]  icmp_base;
    logic [7:0]  field_at;
    logic        have_field;
    logic        hit_hi;
    logic        hit_lo;
    kind_t       kind;

    always_comb
    begin
        outer_len_next = (offset_reg == 8'd0) ? {data_byte[3:0], 2'b00} : outer_len_reg;
        sender_next    = (offset_reg == 8'd0) ? sender_addr : sender_reg;
        outer_ext      = {2'b00, outer_len_next};
        msg_type_next  = (offset_reg == outer_ext) ? data_byte : msg_type_reg;
        icmp_base      = outer_ext + ICMP_HDR_LEN;
        inner_len_next = (offset_reg == icmp_base) ? {data_byte[3:0], 2'b00} : inner_len_reg;

        // inner length is never updated on a byte where it is used
        if (msg_type_next == MSG_ECHO_REPLY)
        begin
            field_at = outer_ext + ECHO_SEQ_OFFSET;
        end
        else
        begin
            field_at = icmp_base + {2'b00, inner_len_reg} + QUOTED_ID_OFFSET;
        end

        have_field = (offset_reg > outer_ext) &&
                     ((msg_type_next == MSG_ECHO_REPLY) ||
                      ((msg_type_next == MSG_TIME_EXCEEDED) && (offset_reg > icmp_base)));
        hit_hi = have_field && (offset_reg == field_at);
        hit_lo = have_field && (offset_reg == field_at + 8'd1);

        priority if (hit_hi)
        begin
            field_next = {data_byte, 8'h00};
        end
        else if (hit_lo)
        begin
            field_next = {field_reg[15:8], data_byte};
        end
        else
        begin
            field_next = field_reg;
        end
        complete_next = complete_reg | hit_lo;
        offset_next   = (offset_reg == OFFSET_MAX) ? offset_reg : offset_reg + 8'd1;

        priority if (offset_reg < outer_ext)
        begin
            kind = KIND_TRUNCATED;
        end
        else if (msg_type_next == MSG_ECHO_REPLY)
        begin
            kind = complete_next ? KIND_ECHO : KIND_TRUNCATED;
        end
        else if (msg_type_next == MSG_TIME_EXCEEDED)
        begin
            kind = complete_next ? KIND_TIME_EXCEEDED : KIND_TRUNCATED;
        end
        else
        begin
            kind = KIND_OTHER;
        end
    end

    assign push             = byte_valid && last_byte;
    assign push_data.kind   = kind;
    assign push_data.field  = field_next;
    assign push_data.sender = sender_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            outer_len_reg <= '0;
            msg_type_reg  <= '0;
            inner_len_reg <= '0;
            field_reg     <= '0;
            complete_reg  <= 1'b0;
            sender_reg    <= '0;
        end
        else if (byte_valid)
        begin
            if (last_byte)
            begin
                offset_reg    <= '0;
                outer_len_reg <= '0;
                msg_type_reg  <= '0;
                inner_len_reg <= '0;
                field_reg     <= '0;
                complete_reg  <= 1'b0;
                sender_reg    <= '0;
            end
            else
            begin
                offset_reg    <= offset_next;
                outer_len_reg <= outer_len_next;
                msg_type_reg  <= msg_type_next;
                inner_len_reg <= inner_len_next;
                field_reg     <= field_next;
                complete_reg  <= complete_next;
                sender_reg    <= sender_next;
            end
        end
    end

endmodule

// ----- design/irm_queue.sv -----
module irm_queue
    import irm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  verdict_t push_data,
    output logic     full,
    input  logic     pop,
    output verdict_t pop_data,
    output logic     empty
);

    verdict_t    entry_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    assign full     = (count_reg == 2'(QUEUE_DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/irm_back.sv -----
module irm_back
    import irm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        empty,
    input  verdict_t    head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        matched,
    output kind_t       reply_kind
);

    logic [31:0] dest_reg;
    logic [15:0] seq_reg;
    logic [15:0] id_reg;
    logic        valid_reg,   valid_next;
    logic        matched_reg, matched_next;
    kind_t       kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg <= '0;
            seq_reg  <= '0;
            id_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROBE_DEST_ADDR: dest_reg <= cfg_data;
                REG_PROBE_SEQUENCE:  seq_reg  <= cfg_data[15:0];
                REG_PROBE_ID:        id_reg   <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    assign pop = !empty && (!valid_reg || out_ready);

    always_comb
    begin
        unique case (head.kind)
            KIND_ECHO:          matched_next = (head.sender == dest_reg) && (head.field == seq_reg);
            KIND_TIME_EXCEEDED: matched_next = (head.field == id_reg);
            default:            matched_next = 1'b0;
        endcase
        priority if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            matched_reg <= matched_next;
            kind_reg    <= head.kind;
        end
    end

    assign out_valid  = valid_reg;
    assign matched    = matched_reg;
    assign reply_kind = kind_reg;

endmodule

// ----- design/icmp_reply_matcher_unit.sv -----
// the last byte transfer queues a verdict; the output register then offers it on m_tvalid
// rate: a byte per cycle; with m_tready high a verdict per cycle, even for one-byte packets
// the parser stalls only while the two-entry verdict queue is full, which needs a held output
// reset: rst_n is asynchronous, active low; it clears the parser state, the queue,
// the output valid and the probe registers (all zero)
module icmp_reply_matcher_unit
    import irm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // packet byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte [7:0], sender_addr [39:8]
    input  logic        s_tlast,   // last_byte
    // verdict stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // matched [0], zero fill [7:1]
    output logic [1:0]  m_tuser,   // reply_kind [1:0]
    // probe registers
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic     byte_xfer;
    logic     push;
    verdict_t push_data;
    logic     full;
    logic     pop;
    verdict_t head;
    logic     empty;
    logic     matched;
    kind_t    reply_kind;

    // every byte is taken while the queue has room for a verdict
    assign s_tready  = !full;
    assign byte_xfer = s_tvalid && s_tready;

    // front: walks the headers and captures the compared field
    irm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_xfer),
        .data_byte   (s_tdata[7:0]),
        .last_byte   (s_tlast),
        .sender_addr (s_tdata[39:8]),
        .push        (push),
        .push_data   (push_data)
    );

    // short queue so the parser keeps running while a verdict waits
    irm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    // back: probe compare and the output register
    irm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .matched    (matched),
        .reply_kind (reply_kind)
    );

    assign m_tdata = {7'd0, matched};
    assign m_tuser = reply_kind;

endmodule

// ----- design/irm_checker.sv -----
module irm_checker
    import irm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // a held verdict stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("verdict withdrawn before its transfer");

    // a held verdict does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("verdict changed while stalled");

    // only an echo reply or a time exceeded message can match
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |->
            (m_tuser == KIND_ECHO) || (m_tuser == KIND_TIME_EXCEEDED))
        else $error("match reported for other or truncated packet");

    // fill bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:1] == 7'd0))
        else $error("fill bits of verdict set");

endmodule

bind icmp_reply_matcher_unit irm_checker u_checker (.*);

// ----- tb/sv/irm_verdict_checker.sv -----
module irm_verdict_checker
    import irm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte [7:0], sender_addr [39:8]
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // matched [0], zero fill [7:1]
    input  logic [1:0]  m_tuser,   // reply_kind [1:0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } verdict_due_t;

    verdict_due_t verdicts_due[$];

    // probe copy
    logic [31:0] probe_addr;
    logic [15:0] probe_seq;
    logic [15:0] probe_ident;

    // parse state of the packet in flight
    logic [7:0]  pos;
    logic [5:0]  outer_len;
    logic [7:0]  msg_type;
    logic [5:0]  inner_len;
    logic [15:0] field_word;
    logic        field_done;
    logic [31:0] src_addr;

    task automatic clear_parse();
        pos        = '0;
        outer_len  = '0;
        msg_type   = '0;
        inner_len  = '0;
        field_word = '0;
        field_done = 1'b0;
        src_addr   = '0;
    endtask

    task automatic parse_packet_byte(input logic [7:0] b, input logic lst,
                                     input logic [31:0] snd);
        logic [7:0]   off;
        logic [7:0]   outer_ext;
        logic [7:0]   field_pos;
        logic         in_field;
        verdict_due_t v;
        off       = pos;
        field_pos = '0;
        in_field  = 1'b0;
        if (off == 8'd0)
        begin
            src_addr  = snd;
            outer_len = {b[3:0], 2'b00};
        end
        outer_ext = {2'b00, outer_len};
        if (off == outer_ext)
            msg_type = b;
        if (off > outer_ext)
        begin
            if (msg_type == MSG_ECHO_REPLY)
            begin
                field_pos = outer_ext + ECHO_SEQ_OFFSET;
                in_field  = 1'b1;
            end
            else if (msg_type == MSG_TIME_EXCEEDED)
            begin
                if (off == outer_ext + ICMP_HDR_LEN)
                    inner_len = {b[3:0], 2'b00};
                if (off > outer_ext + ICMP_HDR_LEN)
                begin
                    field_pos = outer_ext + ICMP_HDR_LEN + {2'b00, inner_len}
                                + QUOTED_ID_OFFSET;
                    in_field  = 1'b1;
                end
            end
        end
        if (in_field)
        begin
            if (off == field_pos)
                field_word = {b, 8'h00};
            else if (off == field_pos + 8'd1)
            begin
                field_word[7:0] = b;
                field_done      = 1'b1;
            end
        end
        if (pos != OFFSET_MAX)
            pos = pos + 8'd1;
        if (lst)
        begin
            v.hit  = 1'b0;
            v.kind = KIND_OTHER;
            if (off < outer_ext)
                v.kind = KIND_TRUNCATED;
            else if (msg_type == MSG_ECHO_REPLY)
            begin
                if (field_done)
                begin
                    v.kind = KIND_ECHO;
                    v.hit  = (src_addr == probe_addr) && (field_word == probe_seq);
                end
                else
                    v.kind = KIND_TRUNCATED;
            end
            else if (msg_type == MSG_TIME_EXCEEDED)
            begin
                if (field_done)
                begin
                    v.kind = KIND_TIME_EXCEEDED;
                    v.hit  = (field_word == probe_ident);
                end
                else
                    v.kind = KIND_TRUNCATED;
            end
            verdicts_due.push_back(v);
            clear_parse();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_due_t due;
        if (!rst_n)
        begin
            probe_addr  = '0;
            probe_seq   = '0;
            probe_ident = '0;
            clear_parse();
            verdicts_due.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            // the result side first, so a verdict can never meet its own byte
            if (m_tvalid && m_tready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: verdict with none due, expected nothing, actual %0d/%0d",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (m_tdata !== {7'b0, due.hit})
                    begin
                        fail_count++;
                        $display("%0t: matched mismatch, expected %0d, actual %0d",
                                 $time, {7'b0, due.hit}, m_tdata);
                    end
                    if (m_tuser !== due.kind)
                    begin
                        fail_count++;
                        $display("%0t: reply_kind mismatch, expected %0d, actual %0d",
                                 $time, due.kind, m_tuser);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROBE_DEST_ADDR: probe_addr  = cfg_data;
                    REG_PROBE_SEQUENCE:  probe_seq   = cfg_data[15:0];
                    REG_PROBE_ID:        probe_ident = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                parse_packet_byte(s_tdata[7:0], s_tlast, s_tdata[39:8]);
            pending = verdicts_due.size();
        end
    end

endmodule

// ----- tb/sv/icmp_reply_matcher_unit_tb.sv -----
module icmp_reply_matcher_unit_tb
    import irm_pkg::*;
();

    // stimulus budget and run guard
    localparam int ITEM_TARGET  = 1620;
    localparam int PHASES       = 6;
    localparam int MIN_PACKETS  = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int BURST_PHASE  = 2;

    // what a generated packet is meant to look like
    typedef enum int {
        SHAPE_ECHO,
        SHAPE_TIME_EXCEEDED,
        SHAPE_OTHER,
        SHAPE_NOISE
    } shape_e;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_PROBE_DEST_ADDR;
    logic [31:0] cfg_data  = '0;

    int fail_count;
    int pending;

    // stimulus side copy of the probe, only used to aim packets at it
    logic [31:0] probe_addr_w  = '0;
    logic [15:0] probe_seq_w   = '0;
    logic [15:0] probe_ident_w = '0;

    // bytes of the packet being built, and progress counters
    logic [7:0] pkt_bytes[$];
    int         bytes_sent   = 0;
    int         packets_sent = 0;
    int         cycle_count  = 0;
    int         ready_wait   = 0;

    // when set, neither side inserts idle cycles
    bit no_idle = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    icmp_reply_matcher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    irm_verdict_checker i_verdict_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // run guard: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("icmp_reply_matcher_unit_tb failed");
            $finish;
        end
    end

    // verdict receiver: after every transfer draw a random stall with tready low;
    // while no verdict is offered tready simply stays high
    always @(posedge clk)
    begin : verdict_sink
        int stall;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_tready   <= 1'b0;
                ready_wait <= stall;
            end
        end
        else if (ready_wait > 1)
            ready_wait <= ready_wait - 1;
        else
        begin
            ready_wait <= 0;
            m_tready   <= 1'b1;
        end
    end

    // one byte transfer; tvalid is left high so a back-to-back byte never
    // needs to drop and raise it within one time step
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [31:0] src);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {src, b};
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // sender address only counts on the first byte, the rest carry noise
    task automatic send_packet(input logic [31:0] src);
        for (int i = 0; i < pkt_bytes.size(); i++)
        begin
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, (i == 0) ? src : $urandom());
            bytes_sent++;
        end
        packets_sent++;
    endtask

    task automatic one_byte_packet(input logic [7:0] b);
        pkt_bytes.delete();
        pkt_bytes.push_back(b);
        send_packet($urandom());
    endtask

    // builds a packet around the outer ihl; echo and time exceeded packets
    // carry the compared word either equal to the probe or off from it
    task automatic build_packet(input shape_e shape, input int ihl, input int inner,
                                input bit hit, input int tail);
        int          ohl;
        int          fpos;
        int          len;
        logic [15:0] want;
        logic [15:0] word;
        logic [7:0]  ty;
        logic [7:0]  rb;
        ohl  = ihl * 4;
        fpos = 0;
        len  = 1 + tail;
        want = (shape == SHAPE_ECHO) ? probe_seq_w : probe_ident_w;
        if (hit)
            word = want;
        else if ($urandom_range(0, 1) == 1)
            word = want ^ (16'h0001 << $urandom_range(0, 15));   // single bit off
        else
            word = 16'($urandom());
        case (shape)
            SHAPE_ECHO:
            begin
                ty   = MSG_ECHO_REPLY;
                fpos = ohl + ECHO_SEQ_OFFSET;
                len  = fpos + 2 + tail;
            end
            SHAPE_TIME_EXCEEDED:
            begin
                ty   = MSG_TIME_EXCEEDED;
                fpos = ohl + ICMP_HDR_LEN + inner * 4 + QUOTED_ID_OFFSET;
                len  = fpos + 2 + tail;
            end
            SHAPE_OTHER:
            begin
                ty = 8'($urandom_range(0, 255));
                if (ty == MSG_ECHO_REPLY || ty == MSG_TIME_EXCEEDED)
                    ty = ty + 8'd1;
                len = ohl + 1 + tail;
            end
            default:
                ty = '0;
        endcase
        pkt_bytes.delete();
        repeat (len)
        begin
            rb = 8'($urandom_range(0, 255));
            pkt_bytes.push_back(rb);
        end
        if (shape != SHAPE_NOISE)
        begin
            rb           = pkt_bytes[0];
            pkt_bytes[0] = {rb[7:4], ihl[3:0]};
            // with ihl zero the type byte lands on the first byte itself
            pkt_bytes[ohl] = ty;
            if (shape == SHAPE_TIME_EXCEEDED)
            begin
                rb                          = pkt_bytes[ohl + ICMP_HDR_LEN];
                pkt_bytes[ohl + ICMP_HDR_LEN] = {rb[7:4], inner[3:0]};
            end
            if (shape != SHAPE_OTHER)
            begin
                pkt_bytes[fpos]     = word[15:8];
                pkt_bytes[fpos + 1] = word[7:0];
            end
        end
    endtask

    // mostly well-formed replies with random content, some other types,
    // some raw noise; a share is cut short and now and then one runs past
    // the point where the byte offset saturates
    task automatic random_packet(input bit burst);
        shape_e      shape;
        int          pick;
        int          ihl;
        int          inner;
        int          tail;
        int          keep;
        logic [31:0] src;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            shape = SHAPE_ECHO;
        else if (pick < 75)
            shape = SHAPE_TIME_EXCEEDED;
        else if (pick < 88)
            shape = SHAPE_OTHER;
        else
            shape = SHAPE_NOISE;
        ihl   = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
        inner = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
        // a time exceeded type byte cannot double as an ihl of zero
        if (shape == SHAPE_TIME_EXCEEDED && ihl == 0)
            ihl = 1;
        if (packets_sent % 25 == 12)
            tail = $urandom_range(240, 300);
        else
            tail = $urandom_range(0, 8);
        build_packet(shape, ihl, inner, $urandom_range(0, 3) != 0, tail);
        if ($urandom_range(0, 6) == 0 && pkt_bytes.size() > 1)
        begin
            keep = $urandom_range(1, pkt_bytes.size() - 1);
            while (pkt_bytes.size() > keep)
                void'(pkt_bytes.pop_back());
        end
        pick = $urandom_range(0, 3);
        if (pick == 0)
            src = $urandom();
        else if (pick == 1)
            src = probe_addr_w ^ (32'h1 << $urandom_range(0, 31));
        else
            src = probe_addr_w;
        no_idle = burst || ($urandom_range(0, 4) == 0);
        send_packet(src);
    endtask

    // the sender holds off until every verdict due has come back and the
    // two-stage verdict path has settled
    task automatic wait_for_verdicts();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // the two 16-bit registers get junk in the upper data bits
    task automatic write_probe(input logic [31:0] addr, input logic [15:0] seq,
                               input logic [15:0] ident);
        logic [15:0] junk;
        probe_addr_w  = addr;
        probe_seq_w   = seq;
        probe_ident_w = ident;
        cfg_we    <= 1'b1;
        cfg_index <= REG_PROBE_DEST_ADDR;
        cfg_data  <= addr;
        @(posedge clk);
        junk = 16'($urandom());
        cfg_index <= REG_PROBE_SEQUENCE;
        cfg_data  <= {junk, seq};
        @(posedge clk);
        junk = 16'($urandom());
        cfg_index <= REG_PROBE_ID;
        cfg_data  <= {junk, ident};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int quota;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_probe(32'hC0A8_0A01, 16'h1234, 16'hBEEF);

        // directed: echo with ihl zero so the type sits on the first byte
        build_packet(SHAPE_ECHO, 0, 0, 1'b1, 0);
        send_packet(probe_addr_w);
        // lone bytes: ends before the type, ends before the echo sequence,
        // and an unknown type on the first byte
        one_byte_packet(8'hFF);
        one_byte_packet(8'h00);
        one_byte_packet(8'hF0);
        // time exceeded with a small outer and an empty quoted header
        build_packet(SHAPE_TIME_EXCEEDED, 1, 0, 1'b1, 0);
        send_packet($urandom());

        // random phases, each under its own probe; the first two use the
        // register extremes and one phase runs without any idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_verdicts();
            case (phase)
                0:       write_probe(32'h0000_0000, 16'h0000, 16'h0000);
                1:       write_probe(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
                default: write_probe($urandom(), 16'($urandom()), 16'($urandom()));
            endcase
            quota = ITEM_TARGET * (phase + 1) / PHASES;
            while (bytes_sent < quota || (phase == PHASES - 1 && packets_sent < MIN_PACKETS))
                random_packet(phase == BURST_PHASE);
        end

        wait_for_verdicts();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("icmp_reply_matcher_unit_tb passed");
        else
            $display("icmp_reply_matcher_unit_tb failed");
        $finish;
    end

endmodule
